[design/plcl_pkg.sv]
package plcl_pkg;

  localparam int FUNC_W         = 1;
  localparam int IDX_W          = 8;
  localparam int WL_W           = 24;
  localparam int VAL_W          = 16;
  localparam int ST_W           = 2;
  localparam int SEG_W          = 8;
  localparam int CNT_W          = 9;
  localparam int PROD_W         = WL_W + VAL_W;
  localparam int MAX_POINTS_DEF = 256;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD  = 1'b0,
    FN_QUERY = 1'b1
  } func_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_LOAD = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [WL_W-1:0]  wl;
    logic [VAL_W-1:0] val;
  } point_t;

endpackage

[design/plcl_if.sv]
interface plcl_req_if;
  logic                           valid;
  logic                           ready;
  plcl_pkg::func_t                func;
  logic [plcl_pkg::IDX_W-1:0]     point_index;
  logic [plcl_pkg::WL_W-1:0]      wavelength;
  logic [plcl_pkg::VAL_W-1:0]     point_value;

  modport source (output valid, func, point_index, wavelength, point_value, input ready);
  modport sink   (input valid, func, point_index, wavelength, point_value, output ready);
endinterface

interface plcl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [plcl_pkg::VAL_W-1:0]     response;
  plcl_pkg::status_t              status;
  logic [plcl_pkg::SEG_W-1:0]     segment;

  modport source (output valid, response, status, segment, input ready);
  modport sink   (input valid, response, status, segment, output ready);
endinterface

[design/plcl_div.sv]
module plcl_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [plcl_pkg::PROD_W-1:0]   dividend,
  input  logic [plcl_pkg::WL_W-1:0]     divisor,
  output logic                          done,
  output logic [plcl_pkg::VAL_W-1:0]    quotient
);

  localparam int STEP_W = $clog2(plcl_pkg::PROD_W + 1);

  logic                          run;
  logic [STEP_W-1:0]             step;
  logic [plcl_pkg::PROD_W-1:0]   acc;
  logic [plcl_pkg::WL_W-1:0]     rem;
  logic [plcl_pkg::WL_W-1:0]     den;
  logic [plcl_pkg::WL_W:0]       rem_sh;
  logic [plcl_pkg::WL_W:0]       rem_diff;
  logic                          ge;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, acc[plcl_pkg::PROD_W-1]};
    rem_diff = rem_sh - {1'b0, den};
    ge       = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == STEP_W'(plcl_pkg::PROD_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (run) begin
      acc <= {acc[plcl_pkg::PROD_W-2:0], ge};
      rem <= ge ? rem_diff[plcl_pkg::WL_W-1:0] : rem_sh[plcl_pkg::WL_W-1:0];
    end
  end

  assign quotient = acc[plcl_pkg::VAL_W-1:0];

endmodule

[design/piecewise_linear_curve_lookup.sv]
// Piecewise linear curve lookup.
// req channel (valid/ready): func selects a load or a query. A load writes
// (wavelength, point_value) at point_index and answers with status load. A
// query evaluates the curve at wavelength and answers with the interpolated
// response, status ok and the lower segment index, or zero with status miss.
// rsp channel (valid/ready): exactly one beat per request beat, in order.
// cfg_we/cfg_wdata set point_count; write it only while the block is idle.
// Path: a load, and a query that misses on count, go from idle to the done state. A query
// that misses on span goes through the first and last point reads; a hit on segment i
// also walks the scan (one table read per scanned point through the single memory read
// port), one multiply and 40 divider steps before the done state and the output register.
// The block works on one request at a time; req.ready is high when idle,
// also while an earlier response beat still waits in the output register.
// When the receiver stalls, a finished result waits until that register
// frees. Reset clears point_count and all control state; table contents
// are undefined until loaded. No clearing pass.
module piecewise_linear_curve_lookup #(
  parameter int MAX_POINTS = plcl_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [plcl_pkg::CNT_W-1:0]  cfg_wdata,
  plcl_req_if.sink                    req,
  plcl_rsp_if.source                  rsp
);

  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int CMPW = (NW > plcl_pkg::CNT_W) ? NW : plcl_pkg::CNT_W;

  plcl_pkg::point_t                 mem [MAX_POINTS];
  plcl_pkg::point_t                 rd_data;
  logic [AW-1:0]                    rd_addr;
  logic                             mem_we;

  plcl_pkg::state_t                 state, state_next;
  logic [plcl_pkg::CNT_W-1:0]       point_count;
  logic [NW-1:0]                    n_lim, n_last, k, kp1;
  logic [plcl_pkg::WL_W-1:0]        x;
  plcl_pkg::point_t                 prev, p0, p1;
  logic [plcl_pkg::PROD_W-1:0]      prod;
  logic                             neg;
  logic [plcl_pkg::VAL_W-1:0]       res_val;
  plcl_pkg::status_t                res_st;
  logic [plcl_pkg::SEG_W-1:0]       res_seg;

  logic                             accept, is_load, hit, span_miss, out_free;
  logic                             div_start, div_done;
  logic [plcl_pkg::VAL_W-1:0]       q;
  logic [plcl_pkg::VAL_W-1:0]       df;
  logic [plcl_pkg::WL_W-1:0]        dx, den;

  // ---- config ----
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_we) begin
      point_count <= cfg_wdata;
    end
  end

  always_comb begin
    n_lim  = (CMPW'(point_count) > CMPW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(point_count);
    n_last = n_lim - 1'b1;
    kp1    = k + 1'b1;
  end

  // ---- control ----
  assign accept    = req.valid && req.ready;
  assign is_load   = (req.func == plcl_pkg::FN_LOAD);
  assign mem_we    = accept && is_load && (int'(req.point_index) < MAX_POINTS);
  assign hit       = (prev.wl <= x) && (rd_data.wl > x);
  assign span_miss = (x < prev.wl) || (x > rd_data.wl);
  assign out_free  = !rsp.valid || rsp.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      plcl_pkg::S_IDLE: begin
        if (req.valid) begin
          if (is_load || n_lim < NW'(2)) state_next = plcl_pkg::S_DONE;
          else                           state_next = plcl_pkg::S_FIRST;
        end
      end
      plcl_pkg::S_FIRST: state_next = plcl_pkg::S_LAST;
      plcl_pkg::S_LAST: begin
        state_next = span_miss ? plcl_pkg::S_DONE : plcl_pkg::S_SCAN;
      end
      plcl_pkg::S_SCAN: begin
        priority if (hit)          state_next = plcl_pkg::S_MUL;
        else if (k == n_last)      state_next = plcl_pkg::S_DONE;
        else                       state_next = plcl_pkg::S_SCAN;
      end
      plcl_pkg::S_MUL:   state_next = plcl_pkg::S_DIVGO;
      plcl_pkg::S_DIVGO: state_next = plcl_pkg::S_DIV;
      plcl_pkg::S_DIV: begin
        if (div_done) state_next = plcl_pkg::S_DONE;
      end
      plcl_pkg::S_DONE: begin
        if (out_free) state_next = plcl_pkg::S_IDLE;
      end
      default: state_next = plcl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    div_start = 1'b0;
    rd_addr   = '0;
    unique case (state)
      plcl_pkg::S_IDLE:  req.ready = 1'b1;
      plcl_pkg::S_FIRST: rd_addr   = n_last[AW-1:0];
      plcl_pkg::S_LAST:  rd_addr   = AW'(1);
      plcl_pkg::S_SCAN:  rd_addr   = kp1[AW-1:0];
      plcl_pkg::S_DIVGO: div_start = 1'b1;
      plcl_pkg::S_MUL, plcl_pkg::S_DIV, plcl_pkg::S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= plcl_pkg::S_IDLE;
    else     state <= state_next;
  end

  // ---- point memory ----
  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(req.point_index)] <= {req.wavelength, req.point_value};
    rd_data <= mem[rd_addr];
  end

  // ---- datapath ----
  always_comb begin
    dx  = x - p0.wl;
    den = p1.wl - p0.wl;
    df  = (p1.val >= p0.val) ? (p1.val - p0.val) : (p0.val - p1.val);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      plcl_pkg::S_IDLE: begin
        x       <= req.wavelength;
        res_val <= '0;
        res_seg <= '0;
        res_st  <= is_load ? plcl_pkg::ST_LOAD : plcl_pkg::ST_MISS;
      end
      plcl_pkg::S_FIRST: prev <= rd_data;
      plcl_pkg::S_LAST:  k    <= NW'(1);
      plcl_pkg::S_SCAN: begin
        if (hit) begin
          p0      <= prev;
          p1      <= rd_data;
          res_seg <= plcl_pkg::SEG_W'(k - 1'b1);
        end else begin
          prev <= rd_data;
          k    <= kp1;
        end
      end
      plcl_pkg::S_MUL: begin
        prod <= df * dx;
        neg  <= (p1.val < p0.val);
      end
      plcl_pkg::S_DIV: begin
        if (div_done) begin
          res_val <= neg ? (p0.val - q) : (p0.val + q);
          res_st  <= plcl_pkg::ST_OK;
        end
      end
      plcl_pkg::S_DIVGO, plcl_pkg::S_DONE: ;
      default: ;
    endcase
  end

  plcl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quotient (q)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == plcl_pkg::S_DONE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == plcl_pkg::S_DONE && out_free) begin
      rsp.response <= res_val;
      rsp.status   <= res_st;
      rsp.segment  <= res_seg;
    end
  end

  // ---- assertions ----
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == plcl_pkg::S_DIV)
    else $error("divider finished outside divide state");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    state == plcl_pkg::S_SCAN |-> (k != '0) && (k <= n_last))
    else $error("scan index out of range");

  a_ok_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == plcl_pkg::S_DONE && res_st == plcl_pkg::ST_OK) |->
      ((res_val >= p0.val && res_val <= p1.val) ||
       (res_val <= p0.val && res_val >= p1.val)))
    else $error("interpolated value outside segment");

  a_beat_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == plcl_pkg::S_DONE)
    else $error("response beat without finished request");

endmodule
